// ===== rtl/lrlw_pkg.sv =====
// Package: shared types and constants for the log-return lag window unit.
`timescale 1ns / 1ps
`default_nettype none
package lrlw_pkg;
	localparam int MONEY_W = 40;
	localparam int VOLUME_W = 32;
	localparam int LIMIT_W = 20;
	localparam int VALUE_W = 21;
	localparam int POS_W = 6;
	localparam int LOG_FRAC = 28;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd661914;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;

	typedef logic [MONEY_W-1:0] money_t;
	typedef logic [VOLUME_W-1:0] volume_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [LIMIT_W-1:0] limit_t;
	typedef logic [LOG_FRAC+6-1:0] log2_t;

	// Control from the top level to the cell row.
	typedef struct packed {
		logic load;
		logic shift;
	} row_ctrl_t;
endpackage
`default_nettype wire

// ===== rtl/lrlw_if.sv =====
// Interfaces: input and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface lrlw_in_if;
	logic valid;
	logic ready;
	lrlw_pkg::money_t money_amount;
	lrlw_pkg::volume_t volume_amount;
	modport source(output valid, money_amount, volume_amount, input ready);
	modport sink(input valid, money_amount, volume_amount, output ready);
endinterface

interface lrlw_out_if;
	logic valid;
	logic ready;
	lrlw_pkg::value_t sample_value;
	lrlw_pkg::pos_t position;
	logic last_of_row;
	modport source(output valid, sample_value, position, last_of_row, input ready);
	modport sink(input valid, sample_value, position, last_of_row, output ready);
endinterface
`default_nettype wire

// ===== rtl/log_return_lag_window_unit.sv =====
// Top level: log-return lag window unit.
// Each nonzero item holds the input while the two log2 units run in parallel (acceptance plus
// one squaring step per fraction bit), then while the unit scales by ln2, forms the delta and
// rounds it, before any word leaves. An item that completes a row then streams WINDOW+1 words
// from the head of a rotating chain of cells, one word per cycle when the sink is ready; a sink
// stall holds the row. Other nonzero items and items with zero money or volume give no word.
`timescale 1ns / 1ps
`default_nettype none
module log_return_lag_window_unit #(
	parameter int WINDOW = 60
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cfg_we,
	input  wire lrlw_pkg::limit_t   cfg_wdata,
	lrlw_in_if.sink                 in_ch,
	lrlw_out_if.source              out_ch
);
	import lrlw_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOG = 3'd1;
	localparam logic [2:0] ST_MUL = 3'd2;
	localparam logic [2:0] ST_DELTA = 3'd3;
	localparam logic [2:0] ST_ROUND = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0] state_q;
	limit_t limit_q;
	logic signed [31:0] prev_q;
	logic seeded_q;
	pos_t fill_q;
	pos_t emit_q;
	logic start_s;
	logic done_m, done_v;
	log2_t lm, lv;
	logic neg_q;
	log2_t mag_q;
	logic [63:0] prod_q;
	logic signed [31:0] cur_log;
	logic signed [40:0] diff_q;
	value_t val_q;
	logic row_shift;
	value_t cells [WINDOW];
	logic [30:0] q26;
	logic signed [32:0] dif;
	logic [40:0] dabs;
	logic [31:0] dm;
	value_t rnd_val;
	logic fill_we;
	value_t head;

	assign start_s = in_ch.valid && in_ch.ready &&
		in_ch.money_amount != '0 && in_ch.volume_amount != '0;
	assign in_ch.ready = (state_q == ST_IDLE);

	lrlw_log2 u_lm (.clk, .arst_n, .start(start_s), .operand(in_ch.money_amount),
		.done(done_m), .result(lm));
	lrlw_log2 u_lv (.clk, .arst_n, .start(start_s),
		.operand(MONEY_W'(in_ch.volume_amount)), .done(done_v), .result(lv));

	// Rotate the row on every word taken; the target enters at the tail on the last one.
	assign row_shift = (state_q == ST_EMIT) && out_ch.ready;

	assign fill_we = state_q == ST_ROUND && !(dm >= 32'(limit_q)) && fill_q < POS_W'(WINDOW);

	genvar g;
	generate
		for (g = 0; g < WINDOW; g++) begin : g_cell
			row_ctrl_t c;
			value_t nv;
			if (g == WINDOW - 1) begin : g_tail
				assign nv = (emit_q == POS_W'(WINDOW)) ? val_q : cells[0];
			end else begin : g_mid
				assign nv = cells[g+1];
			end
			assign c.load = fill_we && fill_q == POS_W'(g);
			assign c.shift = row_shift;
			lrlw_cell u_cell (.clk, .ctrl(c), .load_val(rnd_val), .next_val(nv),
				.val(cells[g]));
		end
	endgenerate

	// Round arithmetic.
	assign q26 = prod_q[62:32];
	assign dif = 33'(cur_log) - 33'(prev_q);
	assign dabs = diff_q[40] ? 41'(-diff_q) : 41'(diff_q);
	assign dm = 32'((dabs + 41'd512) >> 10);
	assign rnd_val = diff_q[40] ? value_t'(-$signed({1'b0, dm[VALUE_W-1:0]}))
		: value_t'(dm[VALUE_W-1:0]);

	// Sequence one item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			limit_q <= LIMIT_RESET;
			prev_q <= '0;
			seeded_q <= 1'b0;
			fill_q <= '0;
			emit_q <= '0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			unique case (state_q)
				ST_IDLE: if (start_s) state_q <= ST_LOG;
				ST_LOG: if (done_m && done_v) state_q <= ST_MUL;
				ST_MUL: state_q <= ST_DELTA;
				ST_DELTA: begin
					prev_q <= cur_log;
					seeded_q <= 1'b1;
					state_q <= seeded_q ? ST_ROUND : ST_IDLE;
				end
				ST_ROUND: begin
					emit_q <= '0;
					if (dm >= 32'(limit_q)) state_q <= ST_IDLE;
					else if (fill_q < POS_W'(WINDOW)) begin
						fill_q <= fill_q + POS_W'(1);
						state_q <= ST_IDLE;
					end else state_q <= ST_EMIT;
				end
				ST_EMIT: if (out_ch.ready) begin
					emit_q <= emit_q + POS_W'(1);
					if (emit_q == POS_W'(WINDOW)) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOG && done_m && done_v) begin
			neg_q <= lv > lm;
			mag_q <= (lv > lm) ? lv - lm : lm - lv;
		end
		if (state_q == ST_MUL) begin
			prod_q <= 64'(mag_q) * 64'(LN2_Q30) + 64'h8000_0000;
		end
		if (state_q == ST_DELTA) diff_q <= 41'(dif) * 41'sd100;
		if (state_q == ST_ROUND) val_q <= rnd_val;
	end

	// Signed log in Q26 is formed once the product is ready.
	always_comb begin
		cur_log = neg_q ? -$signed({1'b0, q26}) : $signed({1'b0, q26});
	end

	// Head word goes out; the target follows the last window word.
	assign head = cells[0];
	assign out_ch.valid = (state_q == ST_EMIT);
	assign out_ch.sample_value = (emit_q == POS_W'(WINDOW)) ? val_q : head;
	assign out_ch.position = emit_q;
	assign out_ch.last_of_row = (emit_q == POS_W'(WINDOW));
endmodule
`default_nettype wire

// ===== rtl/lrlw_log2.sv =====
// Iterative log2 unit: leading-one search then one squaring per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lrlw_log2 (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  wire lrlw_pkg::money_t operand,
	output logic                 done,
	output lrlw_pkg::log2_t      result
);
	import lrlw_pkg::*;

	logic [5:0] exp_q;
	logic [32:0] mant_q;
	logic [LOG_FRAC-1:0] frac_q;
	logic [4:0] step_q;
	logic busy_q;
	logic [5:0] lead;
	logic [32:0] norm;
	logic [65:0] sq;
	logic [34:0] sq_sh;

	// Find the leading one.
	always_comb begin
		lead = '0;
		for (int i = 0; i < MONEY_W; i++) begin
			if (operand[i]) lead = 6'(i);
		end
		if (lead >= 6'd31) norm = 33'(operand >> (lead - 6'd31));
		else norm = 33'(operand << (6'd31 - lead));
	end

	assign sq = mant_q * mant_q;
	assign sq_sh = sq[65:31];

	// Advance one fraction bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'(LOG_FRAC - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			exp_q <= lead;
			mant_q <= norm;
			frac_q <= '0;
		end else if (busy_q) begin
			if (sq_sh[34:32] != 3'd0) begin
				mant_q <= sq_sh[33:1];
				frac_q <= {frac_q[LOG_FRAC-2:0], 1'b1};
			end else begin
				mant_q <= sq_sh[32:0];
				frac_q <= {frac_q[LOG_FRAC-2:0], 1'b0};
			end
		end
	end

	assign result = {exp_q, frac_q};
endmodule
`default_nettype wire

// ===== rtl/lrlw_cell.sv =====
// One window cell: holds a sample and hands it to its neighbor on a shift.
`timescale 1ns / 1ps
`default_nettype none
module lrlw_cell (
	input  wire                   clk,
	input  wire lrlw_pkg::row_ctrl_t ctrl,
	input  wire lrlw_pkg::value_t  load_val,
	input  wire lrlw_pkg::value_t  next_val,
	output lrlw_pkg::value_t       val
);
	import lrlw_pkg::*;

	value_t val_q;

	// Load a new sample or take the neighbor's.
	always_ff @(posedge clk) begin
		if (ctrl.load) val_q <= load_val;
		else if (ctrl.shift) val_q <= next_val;
	end

	assign val = val_q;
endmodule
`default_nettype wire

// ===== rtl/lrlw_checker.sv =====
// Checker on the top level's ports, bound to the unit.
`timescale 1ns / 1ps
`default_nettype none
module lrlw_checker #(
	parameter int WINDOW = 60
) (
	input wire clk,
	input wire arst_n,
	input wire out_valid,
	input wire out_ready,
	input wire [5:0] out_position,
	input wire out_last,
	input wire in_ready
);
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_position == 6'(WINDOW)))) else $error("last flag");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken during row");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid &&
		out_position == $past(out_position) + 6'd1) else $error("position step");
endmodule

bind log_return_lag_window_unit lrlw_checker #(.WINDOW(WINDOW)) u_chk (.clk(clk),
	.arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_position(out_ch.position), .out_last(out_ch.last_of_row), .in_ready(in_ch.ready));
`default_nettype wire
